### sv/egcd_pkg.sv
package egcd_pkg;

  // Default word width of the operands and of every result field.
  localparam int unsigned DataWidthDefault = 32;

endpackage

### sv/egcd_div.sv
// Restoring unsigned divider, one quotient bit per cycle, MSB first.
// While the quotient bits come out, two Horner accumulators form
// quotient * mul_x and quotient * mul_y modulo 2^DATA_WIDTH.
module egcd_div
  import egcd_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DATA_WIDTH-1:0] dividend_i,
  input  logic [DATA_WIDTH-1:0] divisor_i,
  input  logic [DATA_WIDTH-1:0] mul_x_i,
  input  logic [DATA_WIDTH-1:0] mul_y_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] rem_o,
  output logic [DATA_WIDTH-1:0] prod_x_o,
  output logic [DATA_WIDTH-1:0] prod_y_o
);

  localparam int unsigned CntW = $clog2(DATA_WIDTH + 1);

  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] dvd_q, dvd_d;
  logic [DATA_WIDTH-1:0] dvs_q, dvs_d;
  logic [DATA_WIDTH-1:0] mx_q, mx_d;
  logic [DATA_WIDTH-1:0] my_q, my_d;
  logic [DATA_WIDTH-1:0] px_q, px_d;
  logic [DATA_WIDTH-1:0] py_q, py_d;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  fits;

  // The partial remainder stays below the divisor, so it always fits in
  // DATA_WIDTH bits once the trial subtraction has been resolved.
  assign trial = {rem_q, dvd_q[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    mx_d   = mx_q;
    my_d   = my_q;
    px_d   = px_q;
    py_d   = py_q;
    if (start_i) begin
      cnt_d  = CntW'(DATA_WIDTH);
      busy_d = 1'b1;
      rem_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      mx_d   = mul_x_i;
      my_d   = mul_y_i;
      px_d   = '0;
      py_d   = '0;
    end else if (busy_q) begin
      rem_d = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      dvd_d = {dvd_q[DATA_WIDTH-2:0], 1'b0};
      px_d  = {px_q[DATA_WIDTH-2:0], 1'b0} + (fits ? mx_q : '0);
      py_d  = {py_q[DATA_WIDTH-2:0], 1'b0} + (fits ? my_q : '0);
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    mx_q  <= mx_d;
    my_q  <= my_d;
    px_q  <= px_d;
    py_q  <= py_d;
  end

  assign done_o   = done_q;
  assign rem_o    = rem_q;
  assign prod_x_o = px_q;
  assign prod_y_o = py_q;

endmodule

### sv/extended_gcd.sv
// Extended Euclidean algorithm: gcd and Bezout coefficients of two signed words.
// The slave channel carries one transaction per problem, operand_a in the low
// half of s_axis_tdata and operand_b above it. The master channel returns one
// transaction with gcd_value, coef_x and coef_y, lowest field first, such that
// operand_a*coef_x + operand_b*coef_y equals gcd_value modulo 2^DATA_WIDTH.
// The block takes one problem at a time: s_axis_tready is high only while the
// sequencer is idle. Each Euclid step is one check state and then a run on the
// single bit-serial divider, which also forms both quotient products. The result
// goes into the output register, and the sequencer then returns to idle to take
// the next problem; 32-bit operands need at most about 46 Euclid steps.
// The finished result sits in an output register; a new problem is accepted
// while it waits, and the sequencer holds its next result until the receiver
// takes the previous one, so a stall on the master side never loses data.
// An asynchronous active-low reset returns the sequencer to idle and clears
// the output valid flag.
module extended_gcd
  import egcd_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDefault,
  localparam int unsigned InW  = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned OutW = ((3 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: operand_a, operand_b, zero fill to whole bytes.
  input  logic [InW-1:0]        s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: gcd_value, coef_x, coef_y, zero fill to whole bytes.
  output logic [OutW-1:0]       m_axis_tdata
);

  localparam int unsigned W    = DATA_WIDTH;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCheck = 2'd1;
  localparam logic [1:0] StDiv   = 2'd2;
  localparam logic [1:0] StFin   = 2'd3;

  logic [1:0]   state_q, state_d;
  logic [W-1:0] a_q, a_d, b_q, b_d;
  logic [W-1:0] xp_q, xp_d, yp_q, yp_d, xc_q, xc_d, yc_q, yc_d;
  logic         sa_q, sa_d, sb_q, sb_d;
  logic         ovalid_q, ovalid_d;
  logic [W-1:0] og_q, og_d, ox_q, ox_d, oy_q, oy_d;

  logic         div_start, div_done;
  logic [W-1:0] div_rem, div_px, div_py;
  logic [W-1:0] mag_a, mag_b;
  logic [W-1:0] rem_s, px_s, py_s;
  logic         out_free;

  assign mag_a    = a_q[W-1] ? (~a_q + 1'b1) : a_q;
  assign mag_b    = b_q[W-1] ? (~b_q + 1'b1) : b_q;
  assign out_free = !ovalid_q || m_axis_tready;

  // Signed fix-up of the unsigned division: the remainder follows the
  // dividend's sign, the quotient is negative when the signs differ.
  assign rem_s = sa_q ? (~div_rem + 1'b1) : div_rem;
  assign px_s  = (sa_q != sb_q) ? (~div_px + 1'b1) : div_px;
  assign py_s  = (sa_q != sb_q) ? (~div_py + 1'b1) : div_py;

  egcd_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(mag_a),
    .divisor_i (mag_b),
    .mul_x_i   (xc_q),
    .mul_y_i   (yc_q),
    .done_o    (div_done),
    .rem_o     (div_rem),
    .prod_x_o  (div_px),
    .prod_y_o  (div_py)
  );

  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    b_d       = b_q;
    xp_d      = xp_q;
    yp_d      = yp_q;
    xc_d      = xc_q;
    yc_d      = yc_q;
    sa_d      = sa_q;
    sb_d      = sb_q;
    ovalid_d  = ovalid_q;
    og_d      = og_q;
    ox_d      = ox_q;
    oy_d      = oy_q;
    div_start = 1'b0;

    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          a_d     = s_axis_tdata[W-1:0];
          b_d     = s_axis_tdata[2*W-1:W];
          xp_d    = W'(1);
          yp_d    = '0;
          xc_d    = '0;
          yc_d    = W'(1);
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (b_q == '0) begin
          state_d = StFin;
        end else begin
          sa_d      = a_q[W-1];
          sb_d      = b_q[W-1];
          div_start = 1'b1;
          state_d   = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          a_d     = b_q;
          b_d     = rem_s;
          xp_d    = xc_q;
          yp_d    = yc_q;
          xc_d    = xp_q - px_s;
          yc_d    = yp_q - py_s;
          state_d = StCheck;
        end
      end
      StFin: begin
        if (out_free) begin
          // A negative final value flips the signs of all three results.
          og_d     = a_q[W-1] ? (~a_q + 1'b1) : a_q;
          ox_d     = a_q[W-1] ? (~xp_q + 1'b1) : xp_q;
          oy_d     = a_q[W-1] ? (~yp_q + 1'b1) : yp_q;
          ovalid_d = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    b_q  <= b_d;
    xp_q <= xp_d;
    yp_q <= yp_d;
    xc_q <= xc_d;
    yc_q <= yc_d;
    sa_q <= sa_d;
    sb_q <= sb_d;
    og_q <= og_d;
    ox_q <= ox_d;
    oy_q <= oy_d;
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = OutW'({oy_q, ox_q, og_q});

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

// Testbench for the extended Euclidean block. A queue of problems feeds a clocked
// driver on the slave stream. The driver predicts each solution at the moment its
// transaction is accepted. A clocked monitor on the master stream checks every
// returned transaction against the oldest prediction, field by field.
module testbench;
  import egcd_pkg::*;

  localparam int unsigned DataWidth     = DataWidthDefault;
  // Stream widths: packed fields, filled with zeros to whole bytes.
  localparam int unsigned InWidth       = ((2 * DataWidth + 7) / 8) * 8;
  localparam int unsigned OutWidth      = ((3 * DataWidth + 7) / 8) * 8;
  localparam int unsigned ResetCycles   = 12;
  localparam int unsigned RandomPerMix  = 100;
  // The long receiver hold-off outlasts two full worst-case problems. That lets
  // the block park one result and then stall its slave side.
  localparam int unsigned HoldOffCycles = 4000;
  // The hold-off and a random stall can come on top of the slowest problem, so the
  // watchdog allows a generous margin.
  localparam int unsigned StallLimit    = 20000;
  localparam int unsigned DrainCycles   = 100;

  typedef logic [DataWidth-1:0] word_t;
  // The first member of a packed struct sits in the most significant bits, so the
  // members are listed from the top field down to match the stream layout.
  typedef struct packed {
    word_t operand_b;
    word_t operand_a;
  } problem_t;
  typedef struct packed {
    word_t coef_y;
    word_t coef_x;
    word_t gcd_value;
  } solution_t;

  localparam word_t MinWord = {1'b1, {(DataWidth - 1){1'b0}}};
  localparam word_t MaxWord = ~MinWord;
  localparam word_t NegOne  = '1;

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InWidth-1:0]  s_tdata  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutWidth-1:0] m_tdata;

  problem_t    problem_queue[$];
  solution_t   expected_solutions[$];
  word_t       fib[$];

  // The initial block sets the two percentages and the hold arm on a falling edge. The
  // clocked processes read them on the rising edge.
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  bit          hold_armed         = 1'b0;
  bit          hold_taken         = 1'b0;
  int unsigned hold_left          = 0;

  int unsigned problems_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned failures        = 0;
  int unsigned quiet_cycles    = 0;

  solution_t observed_solution;
  solution_t predicted_solution;

  extended_gcd #(
    .DATA_WIDTH(DataWidth)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Euclid's iteration with truncating signed division. The quotient rounds
  // toward zero and the remainder takes the dividend's sign. All arithmetic
  // wraps at the word width. The most negative value divided by minus one gives
  // the most negative quotient and a zero remainder.
  function automatic solution_t bezout_predict(input problem_t prob);
    word_t     rem_prev, rem_cur, rem_next;
    word_t     x_prev, x_cur, y_prev, y_cur, swap;
    word_t     mag_prev, mag_cur, quo_mag, rem_mag, quo;
    solution_t sol;
    rem_prev = prob.operand_a;
    rem_cur  = prob.operand_b;
    x_prev   = word_t'(1);
    x_cur    = '0;
    y_prev   = '0;
    y_cur    = word_t'(1);
    while (rem_cur != '0) begin
      mag_prev = rem_prev[DataWidth-1] ? -rem_prev : rem_prev;
      mag_cur  = rem_cur[DataWidth-1] ? -rem_cur : rem_cur;
      quo_mag  = mag_prev / mag_cur;
      rem_mag  = mag_prev % mag_cur;
      quo      = (rem_prev[DataWidth-1] != rem_cur[DataWidth-1]) ? -quo_mag : quo_mag;
      rem_next = rem_prev[DataWidth-1] ? -rem_mag : rem_mag;
      rem_prev = rem_cur;
      rem_cur  = rem_next;
      swap     = x_cur;
      x_cur    = x_prev - quo * x_cur;
      x_prev   = swap;
      swap     = y_cur;
      y_cur    = y_prev - quo * y_cur;
      y_prev   = swap;
    end
    // A negative final remainder flips all three results so that the gcd is
    // non-negative. The gcd of the most negative value and zero stays 2^(W-1),
    // which fits because the gcd is unsigned.
    if (rem_prev[DataWidth-1]) begin
      rem_prev = -rem_prev;
      x_prev   = -x_prev;
      y_prev   = -y_prev;
    end
    sol.gcd_value = rem_prev;
    sol.coef_x    = x_prev;
    sol.coef_y    = y_prev;
    return sol;
  endfunction

  function automatic problem_t make_problem(input word_t a, input word_t b);
    problem_t prob;
    prob.operand_a = a;
    prob.operand_b = b;
    return prob;
  endfunction

  function automatic word_t signed_small(input int unsigned limit);
    word_t v;
    v = word_t'($urandom_range(limit, 0));
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic word_t pick_extreme();
    case ($urandom_range(5))
      0: return MinWord;
      1: return MaxWord;
      2: return NegOne;
      3: return '0;
      4: return word_t'(1);
      default: return MinWord + word_t'(1);
    endcase
  endfunction

  // Most random problems are ordinary pairs with varied structure. Shared factors
  // give gcds above one. Consecutive Fibonacci numbers force the longest
  // iteration chains. Extremes and zero or unit operands mix in throughout.
  task automatic queue_random(input int unsigned count);
    word_t       a, b, k, t;
    int unsigned idx;
    repeat (count) begin
      case ($urandom_range(5))
        0: begin
          a = word_t'($urandom);
          b = word_t'($urandom);
        end
        1: begin
          k = word_t'($urandom_range(4096, 2));
          a = k * signed_small(65535);
          b = k * signed_small(65535);
        end
        2: begin
          a = signed_small(300);
          b = signed_small(300);
        end
        3: begin
          idx = $urandom_range(fib.size() - 1, 1);
          a   = $urandom_range(1) ? -fib[idx] : fib[idx];
          b   = $urandom_range(1) ? -fib[idx-1] : fib[idx-1];
        end
        4: begin
          a = pick_extreme();
          b = $urandom_range(1) ? pick_extreme() : word_t'($urandom);
        end
        default: begin
          case ($urandom_range(3))
            0:       a = '0;
            1:       a = word_t'(1);
            2:       a = NegOne;
            default: a = MinWord;
          endcase
          b = word_t'($urandom);
        end
      endcase
      if ($urandom_range(1)) begin
        t = a;
        a = b;
        b = t;
      end
      problem_queue.push_back(make_problem(a, b));
    end
  endtask

  // The sender pauses here until the queue is empty and every predicted solution
  // has been returned.
  task automatic wait_drained();
    do @(negedge clk);
    while (problem_queue.size() != 0 || s_tvalid || expected_solutions.size() != 0);
  endtask

  // Driver. The slot is free when nothing is offered or when the current
  // transaction is being accepted at this edge. The prediction is queued at
  // acceptance.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        expected_solutions.push_back(bezout_predict(s_tdata[2*DataWidth-1:0]));
        problems_sent++;
      end
      if (problem_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= InWidth'(problem_queue.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor. It checks each accepted result and then chooses the next ready
  // value. The single long hold-off is counted down here.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        observed_solution = m_tdata[3*DataWidth-1:0];
        if (expected_solutions.size() == 0) begin
          $error("unexpected result transaction: gcd_value %0d, coef_x %0d, coef_y %0d",
                 observed_solution.gcd_value, $signed(observed_solution.coef_x),
                 $signed(observed_solution.coef_y));
          failures++;
        end else begin
          predicted_solution = expected_solutions.pop_front();
          results_checked++;
          if (observed_solution.gcd_value !== predicted_solution.gcd_value) begin
            $error("gcd_value: expected %0d, got %0d",
                   predicted_solution.gcd_value, observed_solution.gcd_value);
            failures++;
          end
          if (observed_solution.coef_x !== predicted_solution.coef_x) begin
            $error("coef_x: expected %0d, got %0d",
                   $signed(predicted_solution.coef_x), $signed(observed_solution.coef_x));
            failures++;
          end
          if (observed_solution.coef_y !== predicted_solution.coef_y) begin
            $error("coef_y: expected %0d, got %0d",
                   $signed(predicted_solution.coef_y), $signed(observed_solution.coef_y));
            failures++;
          end
        end
      end
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Watchdog. It counts consecutive cycles in which neither stream completes a
  // transaction.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned sender_mix[4];
    int unsigned receiver_mix[4];
    longint      fib_next;

    sender_mix   = '{0, 76, 0, 26};
    receiver_mix = '{0, 0, 76, 26};

    // Fibonacci numbers that fit as positive words. Neighboring pairs drive the
    // longest Euclid chains.
    fib.push_back(word_t'(1));
    fib.push_back(word_t'(1));
    fib_next = 2;
    while (fib_next <= longint'(MaxWord)) begin
      fib.push_back(word_t'(fib_next));
      fib_next = longint'(fib[$]) + longint'(fib[$-1]);
    end

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corner problems, with no idling on either side.
    problem_queue.push_back(make_problem('0, '0));              // both operands zero
    problem_queue.push_back(make_problem(word_t'(5), '0));      // b zero, a positive
    problem_queue.push_back(make_problem(-word_t'(5), '0));     // b zero, a negative
    problem_queue.push_back(make_problem(MinWord, '0));         // gcd of 2^(W-1)
    problem_queue.push_back(make_problem('0, word_t'(7)));
    problem_queue.push_back(make_problem('0, -word_t'(7)));
    problem_queue.push_back(make_problem(MinWord, NegOne));     // wrapping division
    problem_queue.push_back(make_problem(NegOne, MinWord));
    problem_queue.push_back(make_problem(MinWord, MinWord));
    problem_queue.push_back(make_problem(MaxWord, MinWord));
    problem_queue.push_back(make_problem(MinWord, MaxWord));
    problem_queue.push_back(make_problem(MaxWord, MaxWord));
    problem_queue.push_back(make_problem(NegOne, NegOne));
    problem_queue.push_back(make_problem(word_t'(1), word_t'(1)));
    problem_queue.push_back(make_problem(word_t'(240), word_t'(46)));
    problem_queue.push_back(make_problem(-word_t'(240), word_t'(46)));
    problem_queue.push_back(make_problem(word_t'(240), -word_t'(46)));
    problem_queue.push_back(make_problem(-word_t'(240), -word_t'(46)));
    problem_queue.push_back(make_problem(MinWord, word_t'(2)));
    problem_queue.push_back(make_problem(-word_t'(7), word_t'(3)));
    // The largest Fibonacci pair needs the most steps, and its coefficients come
    // close to the word limits.
    problem_queue.push_back(make_problem(fib[$], fib[$-1]));
    problem_queue.push_back(make_problem(-fib[$], fib[$-1]));
    problem_queue.push_back(make_problem(fib[$-1], -fib[$]));
    wait_drained();

    // Random problems under four flow-control mixes. The first mix also holds
    // the receiver off long enough for the block to back up onto its slave side.
    for (int mix = 0; mix < 4; mix++) begin
      sender_idle_pct    = sender_mix[mix];
      receiver_stall_pct = receiver_mix[mix];
      if (mix == 0) begin
        hold_armed = 1'b1;
      end
      queue_random(RandomPerMix);
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk);
    if (expected_solutions.size() != 0) begin
      $error("%0d predicted solutions never returned", expected_solutions.size());
      failures++;
    end

    $display("Checked %0d solutions for %0d problems: corner operands, shared factors,",
             results_checked, problems_sent);
    $display("Fibonacci chains and random pairs under four handshake mixes and a %0d-%s",
             HoldOffCycles, "cycle hold-off.");
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
